/* design/lcjh_pkg.sv */
// Package for the lane center jump-hold core: sizes, register indexes,
// queue and result records, and the hold limit helper.
// No dependencies.
`default_nettype none

package lcjh_pkg;

    localparam int NUM_LINES  = 8;
    localparam int X_BITS     = 11;
    localparam int TIMER_BITS = 16;
    localparam int LINE_BITS  = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

    localparam int IDX_BITS   = 4;
    localparam int THR_BITS   = 11;
    localparam int HOLD_BITS  = 16;
    localparam int ROWS_BITS  = 12;
    localparam int PCT_BITS   = 7;
    localparam int Y_BITS     = 12;
    localparam int PROD_BITS  = ROWS_BITS + PCT_BITS;

    // floor(p / 100) = (p * ceil(2^26 / 100)) >> 26, exact for p < 2^19
    localparam int RECIP_BITS  = 20;
    localparam logic [RECIP_BITS-1:0] RECIP_100 = 20'd671089;
    localparam int RECIP_SHIFT = 26;
    localparam int QUOT_BITS   = PROD_BITS + RECIP_BITS - RECIP_SHIFT;
    localparam logic [Y_BITS-1:0] Y_MAX = '1;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_JUMP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_TIME      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROI_ROWS       = 2'd2;

    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [IDX_BITS-1:0] line_index;
        logic [X_BITS-1:0]   mid;
        logic [Y_BITS-1:0]   y;
        logic                index_error;
    } item_t;

    typedef struct packed {
        logic [THR_BITS-1:0]   jump_threshold;
        logic [TIMER_BITS-1:0] limit;
    } hold_cfg_t;

    typedef struct packed {
        logic [X_BITS-1:0] center_x;
        logic [Y_BITS-1:0] center_y;
        logic              holding;
        logic              index_error;
    } result_t;

    // Clamp the hold time to what the timer can count to.
    function automatic logic [TIMER_BITS-1:0] hold_limit(input logic [HOLD_BITS-1:0] ht);
        logic [63:0] ext;
        logic [63:0] tmax;
        ext  = 64'(ht);
        tmax = (64'd1 << TIMER_BITS) - 64'd1;
        return TIMER_BITS'((ext > tmax) ? tmax : ext);
    endfunction

endpackage

`default_nettype wire

/* design/lcjh_front.sv */
// Front end of the lane center core: takes input beats, forms the midpoint,
// row product and index check, then scales y and pushes into the queue. Uses lcjh_pkg.
`default_nettype none

module lcjh_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [lcjh_pkg::IDX_BITS-1:0]  in_line_index,
    input  wire logic [lcjh_pkg::X_BITS-1:0]    in_left_x,
    input  wire logic [lcjh_pkg::X_BITS-1:0]    in_right_x,
    input  wire logic [lcjh_pkg::PCT_BITS-1:0]  in_row_percent,
    input  wire logic [lcjh_pkg::ROWS_BITS-1:0] roi_rows,
    output logic                                push,
    output lcjh_pkg::item_t                     push_item,
    input  wire logic                           q_ready
);
    import lcjh_pkg::*;

    logic                 s1_valid_reg, s1_valid_next;
    logic [IDX_BITS-1:0]  s1_idx_reg;
    logic [X_BITS-1:0]    s1_mid_reg;
    logic [PROD_BITS-1:0] s1_prod_reg;
    logic                 s1_err_reg;
    logic                 take;
    logic [X_BITS:0]      sum;
    logic [PROD_BITS+RECIP_BITS-1:0] scaled;
    logic [QUOT_BITS-1:0] quot;

    assign in_ready = !s1_valid_reg || q_ready;
    assign take     = in_valid && in_ready;
    assign push     = s1_valid_reg && q_ready;
    assign sum      = {1'b0, in_left_x} + {1'b0, in_right_x};

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (take) begin
            s1_valid_next = 1'b1;
        end else if (push) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            s1_idx_reg  <= in_line_index;
            s1_mid_reg  <= sum[X_BITS:1];
            s1_prod_reg <= PROD_BITS'(roi_rows) * PROD_BITS'(in_row_percent);
            s1_err_reg  <= ({1'b0, in_line_index} >= (IDX_BITS + 1)'(NUM_LINES));
        end
    end

    // Divide the row product by 100 and clamp to the y field.
    assign scaled = (PROD_BITS + RECIP_BITS)'(s1_prod_reg) * (PROD_BITS + RECIP_BITS)'(RECIP_100);
    assign quot   = scaled[PROD_BITS+RECIP_BITS-1:RECIP_SHIFT];

    always_comb begin
        push_item.line_index  = s1_idx_reg;
        push_item.mid         = s1_mid_reg;
        push_item.index_error = s1_err_reg;
        push_item.y           = (quot > QUOT_BITS'(Y_MAX)) ? Y_MAX : quot[Y_BITS-1:0];
    end

endmodule

`default_nettype wire

/* design/lcjh_queue.sv */
// Two-entry queue between the front end and the hold tracker.
// Uses lcjh_pkg for the item record and depth.
`default_nettype none

module lcjh_queue (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire lcjh_pkg::item_t push_item,
    output logic            q_ready,
    output logic            q_valid,
    output lcjh_pkg::item_t q_item,
    input  wire logic       pop
);
    import lcjh_pkg::*;

    item_t                 mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0] count_reg, count_next;

    assign q_ready = (count_reg != Q_CNT_BITS'(Q_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_ready || pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_BITS'(Q_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* design/lcjh_back.sv */
// Hold tracker: per-line read-modify-write of center, y, timer and hold
// flags, with a registered result stage. Uses lcjh_pkg.
`default_nettype none

module lcjh_back (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire lcjh_pkg::hold_cfg_t cfg,
    input  wire logic         q_valid,
    input  wire lcjh_pkg::item_t q_item,
    output logic              pop,
    output logic              out_valid,
    output lcjh_pkg::result_t out_result,
    input  wire logic         out_ready
);
    import lcjh_pkg::*;

    logic [X_BITS-1:0]     cx_reg     [NUM_LINES];
    logic [Y_BITS-1:0]     y_reg      [NUM_LINES];
    logic [TIMER_BITS-1:0] timer_reg  [NUM_LINES];
    logic [NUM_LINES-1:0]  active_reg;
    logic [NUM_LINES-1:0]  started_reg;

    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg, out_next;

    logic [LINE_BITS-1:0]  sel;
    logic                  started, jump, take_new;
    logic                  act1, act2;
    logic [X_BITS-1:0]     cx0, cx2, diff;
    logic [TIMER_BITS-1:0] tm0, tm1, tm2;
    logic [Y_BITS-1:0]     y2;

    assign pop        = q_valid && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_comb begin
        sel      = q_item.line_index[LINE_BITS-1:0];
        started  = started_reg[sel];
        // a line's first item seeds center and saturated timer
        cx0      = started ? cx_reg[sel] : q_item.mid;
        tm0      = started ? timer_reg[sel] : cfg.limit;
        diff     = (q_item.mid > cx0) ? (q_item.mid - cx0) : (cx0 - q_item.mid);
        jump     = (diff > cfg.jump_threshold) && !active_reg[sel];
        tm1      = jump ? '0 : tm0;
        act1     = jump || active_reg[sel];
        take_new = (tm1 >= cfg.limit);
        cx2      = take_new ? q_item.mid : cx0;
        act2     = take_new ? 1'b0 : act1;
        tm2      = take_new ? tm1 : (tm1 + TIMER_BITS'(1));
        y2       = started ? y_reg[sel] : q_item.y;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (pop) begin
            out_valid_next = 1'b1;
            if (q_item.index_error) begin
                out_next = '{center_x: '0, center_y: '0, holding: 1'b0, index_error: 1'b1};
            end else begin
                out_next = '{center_x: cx2, center_y: y2, holding: act2, index_error: 1'b0};
            end
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            active_reg    <= '0;
            started_reg   <= '0;
            for (int i = 0; i < NUM_LINES; i++) begin
                timer_reg[i] <= '0;
            end
        end else begin
            out_valid_reg <= out_valid_next;
            if (pop && !q_item.index_error) begin
                active_reg[sel]  <= act2;
                started_reg[sel] <= 1'b1;
                timer_reg[sel]   <= tm2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (pop && !q_item.index_error) begin
            cx_reg[sel] <= cx2;
            y_reg[sel]  <= y2;
        end
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.index_error) |->
            (!out_reg.holding && out_reg.center_x == '0 && out_reg.center_y == '0))
        else $error("error result carries data");
    a_no_hold_zero_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && cfg.limit == '0) |=> !out_reg.holding)
        else $error("hold reported with zero hold limit");
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_ready) |=> $stable(out_reg))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

/* design/lane_center_jump_hold_core.sv */
// Lane center jump-hold core, top level. An input beat passes through the front
// stage, the queue and the result register to the result beat. Throughput: one beat
// per cycle while results are not stalled, set by the per-line update in the tracker.
// Reset (aresetn low, synchronous) empties the pipeline, clears all line
// started/hold flags and timers, and sets threshold 0, hold time 0, rows 1.
`default_nettype none

module lane_center_jump_hold_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [3:0] line_index, [14:4] left_x, [25:15] right_x, [32:26] row_percent
    input  wire logic [39:0] s_axis_tdata,

    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [10:0] center_x, [22:11] center_y
    output logic [23:0]      m_axis_tdata,
    // [0] holding, [1] index_error
    output logic [1:0]       m_axis_tuser,

    // Register write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import lcjh_pkg::*;

    logic [THR_BITS-1:0]  thr_reg;
    logic [HOLD_BITS-1:0] hold_time_reg;
    logic [ROWS_BITS-1:0] rows_reg;

    hold_cfg_t cfg;
    logic      push, q_ready, q_valid, pop;
    item_t     push_item, q_item;
    logic      out_valid;
    result_t   out_result;

    // Configuration: always ready, writes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= '0;
            hold_time_reg <= '0;
            rows_reg      <= ROWS_BITS'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_JUMP_THRESHOLD: thr_reg       <= cfg_data[THR_BITS-1:0];
                REG_HOLD_TIME:      hold_time_reg <= cfg_data[HOLD_BITS-1:0];
                REG_ROI_ROWS:       rows_reg      <= cfg_data[ROWS_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.jump_threshold = thr_reg;
    assign cfg.limit          = hold_limit(hold_time_reg);

    // Front: unpack the beat, form midpoint, y and index check.
    lcjh_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_line_index (s_axis_tdata[3:0]),
        .in_left_x     (s_axis_tdata[14:4]),
        .in_right_x    (s_axis_tdata[25:15]),
        .in_row_percent(s_axis_tdata[32:26]),
        .roi_rows      (rows_reg),
        .push          (push),
        .push_item     (push_item),
        .q_ready       (q_ready)
    );

    // Queue: decouple the front from result backpressure.
    lcjh_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .q_ready  (q_ready),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop)
    );

    // Back: per-line hold tracking and the result register.
    lcjh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_result(out_result),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {1'b0, out_result.center_y, out_result.center_x};
    assign m_axis_tuser  = {out_result.index_error, out_result.holding};

endmodule

`default_nettype wire
